// ===== design/rcw_pkg.sv =====
// Package with shared types and constants of the RIFF chunk walker.
package rcw_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagList = 32'h5453_494C;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrTopNotRiff = 3'd1,
    ErrExceeds  = 3'd2,
    ErrPastEnd  = 3'd3,
    ErrTooDeep  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    CfgFileSize = 2'd0,
    CfgHaltOnError = 2'd1
  } cfg_idx_e;

  // One file byte as it travels on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
  } byte_req_t;

  // Result record as it travels on the output channel, first field on top.
  typedef struct packed {
    logic [39:0] chunk_offset;
    logic [31:0] chunk_id;
    logic [31:0] chunk_size;
    logic [31:0] form_type;
    logic [3:0]  nest_level;
    logic        is_container;
    logic [2:0]  error_code;
  } chunk_rec_t;

endpackage

// ===== design/rcw_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface rcw_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/rcw_front.sv =====
// Front part: input register stage that buffers bytes into a two-entry queue.
module rcw_front #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output logic [7:0] q_byte_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o = (cnt_q != Depth[PtrW:0]);
  assign q_valid_o  = (cnt_q != '0);
  assign q_byte_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Depth[PtrW:0])
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with differing pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("push lost");

endmodule

// ===== design/rcw_back.sv =====
// Back part: header parser, nesting stack and registered result stage.
module rcw_back
  import rcw_pkg::*;
#(
  parameter int unsigned MaxNesting = 8,
  parameter int unsigned OffsetBits = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [39:0]           file_size_i,
  input  logic                  halt_on_error_i,
  input  logic                  b_valid_i,
  output logic                  b_ready_o,
  input  logic [7:0]            b_byte_i,
  output logic                  r_valid_o,
  input  logic                  r_ready_i,
  output logic [39:0]           r_offset_o,
  output logic [31:0]           r_id_o,
  output logic [31:0]           r_size_o,
  output logic [31:0]           r_form_o,
  output logic [3:0]            r_level_o,
  output logic                  r_cont_o,
  output logic [2:0]            r_err_o
);

  localparam int unsigned LvlW = $clog2(MaxNesting + 1);
  localparam int unsigned IdxW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;
  localparam int unsigned OW   = OffsetBits;

  typedef enum logic [1:0] {PhId, PhSize, PhForm, PhSkip} phase_e;

  phase_e             phase_q;
  logic [1:0]         cnt_q;
  logic [OW-1:0]      ofs_q, hdr_ofs_q;
  logic [31:0]        id_q, size_q, form_q;
  logic [32:0]        skip_q;
  logic [OW-1:0]      stk_q [MaxNesting];
  logic [LvlW-1:0]    depth_q, lvl_q;
  logic [2:0]         err_q;
  logic               halted_q;
  // Pop pass: at most one pop per cycle; header start waits until no pop.
  logic               top_done;
  logic               fire;
  logic [OW-1:0]      file_ext;

  logic               o_valid_q;
  logic [39:0]        o_ofs_q;
  logic [31:0]        o_id_q, o_size_q, o_form_q;
  logic [3:0]         o_lvl_q;
  logic [2:0]         o_err_q;

  logic [31:0]        size_full;
  logic [31:0]        form_full;
  logic [32:0]        padded;
  logic [OW:0]        end_sum;
  logic               exceeds;
  logic               is_cont;

  assign file_ext = OW'(file_size_i);
  assign top_done = (depth_q != '0) &&
                    (ofs_q >= stk_q[IdxW'(depth_q - 1'b1)]);
  // Taking a byte needs the output register free; header start needs no pending pop.
  // Once halted, bytes are taken and dropped.
  assign b_ready_o = halted_q ||
                     ((!o_valid_q || r_ready_i) &&
                      !(phase_q == PhId && cnt_q == 2'd0 && top_done));
  assign fire = b_valid_i && b_ready_o;

  assign size_full = {b_byte_i, size_q[23:0]};
  assign form_full = {b_byte_i, form_q[23:0]};
  assign padded    = ({1'b0, size_full} + 33'd1) & ~33'd1;
  assign end_sum   = {1'b0, hdr_ofs_q} + (OW+1)'(8) + (OW+1)'(padded);
  assign exceeds   = end_sum > (OW+1)'(file_ext);
  assign is_cont   = (id_q == TagRiff) || (id_q == TagList);

  assign r_valid_o  = o_valid_q;
  assign r_offset_o = o_ofs_q;
  assign r_id_o     = o_id_q;
  assign r_size_o   = o_size_q;
  assign r_form_o   = o_form_q;
  assign r_level_o  = o_lvl_q;
  assign r_cont_o   = (o_id_q == TagRiff) || (o_id_q == TagList);
  assign r_err_o    = o_err_q;

  always_ff @(posedge clk_i) begin
    if (fire && !halted_q && phase_q == PhForm && cnt_q == 2'd3 &&
        lvl_q < LvlW'(MaxNesting)) begin
      stk_q[IdxW'(lvl_q)] <= hdr_ofs_q + OW'(8) +
        ((lvl_q != '0) ? OW'(({1'b0, size_q} + 33'd1) & ~33'd1) : OW'(size_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhId;
      cnt_q     <= '0;
      ofs_q     <= '0;
      hdr_ofs_q <= '0;
      id_q      <= '0;
      size_q    <= '0;
      form_q    <= '0;
      skip_q    <= '0;
      depth_q   <= '0;
      lvl_q     <= '0;
      err_q     <= ErrNone;
      halted_q  <= 1'b0;
      o_valid_q <= 1'b0;
      o_ofs_q   <= '0;
      o_id_q    <= '0;
      o_size_q  <= '0;
      o_form_q  <= '0;
      o_lvl_q   <= '0;
      o_err_q   <= ErrNone;
    end else begin
      if (r_ready_i) begin
        o_valid_q <= 1'b0;
      end
      if (!halted_q && phase_q == PhId && cnt_q == 2'd0 && top_done) begin
        depth_q <= depth_q - 1'b1;
      end
      if (fire && !halted_q) begin
        ofs_q <= ofs_q + 1'b1;
        unique case (phase_q)
          PhId: begin
            if (cnt_q == 2'd0) begin
              hdr_ofs_q <= ofs_q;
              lvl_q     <= depth_q;
              err_q     <= ErrNone;
              form_q    <= '0;
              id_q      <= {24'd0, b_byte_i};
              if (ofs_q >= file_ext) begin
                halted_q <= 1'b1;
                if (depth_q != '0) begin
                  o_valid_q <= 1'b1;
                  o_ofs_q   <= 40'(ofs_q);
                  o_id_q    <= '0;
                  o_size_q  <= '0;
                  o_form_q  <= '0;
                  o_lvl_q   <= 4'(depth_q);
                  o_err_q   <= ErrPastEnd;
                end
              end
            end else begin
              id_q[cnt_q*8 +: 8] <= b_byte_i;
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 2'd3) begin
              phase_q <= PhSize;
            end
          end
          PhSize: begin
            size_q[cnt_q*8 +: 8] <= b_byte_i;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 2'd3) begin
              phase_q <= PhId;
              o_ofs_q  <= 40'(hdr_ofs_q);
              o_id_q   <= id_q;
              o_size_q <= size_full;
              o_form_q <= '0;
              o_lvl_q  <= 4'(lvl_q);
              if (lvl_q == '0 && id_q != TagRiff) begin
                o_valid_q <= 1'b1;
                o_err_q   <= ErrTopNotRiff;
                halted_q  <= 1'b1;
              end else if (exceeds && halt_on_error_i) begin
                o_valid_q <= 1'b1;
                o_err_q   <= ErrExceeds;
                halted_q  <= 1'b1;
              end else begin
                if (exceeds) begin
                  err_q <= ErrExceeds;
                end
                if (is_cont) begin
                  phase_q <= PhForm;
                end else begin
                  o_valid_q <= 1'b1;
                  o_err_q   <= exceeds ? ErrExceeds : ErrNone;
                  skip_q    <= padded;
                  if (padded != '0) begin
                    phase_q <= PhSkip;
                  end
                end
              end
            end
          end
          PhForm: begin
            form_q[cnt_q*8 +: 8] <= b_byte_i;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 2'd3) begin
              phase_q   <= PhId;
              o_valid_q <= 1'b1;
              o_ofs_q   <= 40'(hdr_ofs_q);
              o_id_q    <= id_q;
              o_size_q  <= size_q;
              o_form_q  <= form_full;
              o_lvl_q   <= 4'(lvl_q);
              if (lvl_q >= LvlW'(MaxNesting)) begin
                o_err_q  <= ErrTooDeep;
                halted_q <= 1'b1;
              end else begin
                o_err_q <= err_q;
                depth_q <= lvl_q + 1'b1;
              end
            end
          end
          PhSkip: begin
            cnt_q  <= '0;
            skip_q <= skip_q - 1'b1;
            if (skip_q <= 33'd1) begin
              phase_q <= PhId;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= LvlW'(MaxNesting))
    else $error("nesting depth beyond limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !r_ready_i && !halted_q) |-> !fire)
    else $error("byte taken while result stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) |-> halted_q)
    else $error("left halt without reset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |-> (skip_q != '0))
    else $error("skip phase with nothing left");

endmodule

// ===== design/riff_chunk_walker.sv =====
// Top level of the RIFF chunk walker: byte queue, parser and config registers.
//
// Usage: the file is fed one byte per request on in_if (valid/ready). After
// each chunk header one result request appears on out_if: chunk offset, id,
// size, form type (containers), nesting level, container flag and error code.
// Plain chunks report after their eighth header byte, RIFF/LIST containers
// after their four form-type bytes. The completing byte passes through the
// front queue and the result is registered. Throughput is one byte per cycle
// unless the result stalls or a level is popped: when containers end at or
// before the next header, the parser holds the bytes while it pops each
// closed level; the two-entry byte queue in front absorbs short bubbles.
// file_size and halt_on_error are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while the block is idle, which
// the block does not enforce. Reset (rst_ni low) clears the parser, empties
// the queue and restores file_size 0, halt_on_error 1. When the receiver
// stalls out_if, the result holds and the parser takes no further byte until
// it is accepted; bytes keep queueing until the queue is full. At end of file
// and after any error but ErrExceeds with halt_on_error 0, the block halts
// and drops incoming bytes without results until reset.
module riff_chunk_walker
  import rcw_pkg::*;
#(
  parameter int unsigned MAX_NESTING = 8,
  parameter int unsigned OFFSET_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  rcw_stream_if.sink  in_if,
  rcw_stream_if.source out_if
);

  logic [39:0] file_size_q;
  logic        halt_q;
  logic        b_valid, b_ready;
  logic [7:0]  b_byte;

  // Offsets are kept modulo 2^OFFSET_BITS, so the configured size is masked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      halt_q      <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFileSize) begin
        file_size_q <= 40'(OFFSET_BITS'(cfg_data_i));
      end else if (cfg_idx_i == CfgHaltOnError) begin
        halt_q <= cfg_data_i[0];
      end
    end
  end

  rcw_front #(.Depth(2)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_byte_i  (in_if.data.data_byte),
    .q_valid_o  (b_valid),
    .q_ready_i  (b_ready),
    .q_byte_o   (b_byte)
  );

  rcw_back #(.MaxNesting(MAX_NESTING), .OffsetBits(OFFSET_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .file_size_i     (file_size_q),
    .halt_on_error_i (halt_q),
    .b_valid_i       (b_valid),
    .b_ready_o       (b_ready),
    .b_byte_i        (b_byte),
    .r_valid_o       (out_if.valid),
    .r_ready_i       (out_if.ready),
    .r_offset_o      (out_if.data.chunk_offset),
    .r_id_o          (out_if.data.chunk_id),
    .r_size_o        (out_if.data.chunk_size),
    .r_form_o        (out_if.data.form_type),
    .r_level_o       (out_if.data.nest_level),
    .r_cont_o        (out_if.data.is_container),
    .r_err_o         (out_if.data.error_code)
  );

endmodule

// ===== sim/riff_chunk_walker_tb.sv =====
// Testbench of the RIFF chunk walker: stream-driven chunk trees checked by a predictor.
module riff_chunk_walker_tb;
  import rcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxNest = 8;
  localparam logic [39:0] OfsMax = 40'hFF_FFFF_FFFF;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ByteGoal = 1200;

  typedef logic [7:0] bytes_t[$];

  typedef enum logic [1:0] {
    WalkId, WalkSize, WalkForm, WalkSkip
  } walk_phase_e;

  // Directed chunks placed inside one top-level RIFF.
  typedef struct {
    logic [31:0] id;
    logic [31:0] size;
    logic [31:0] form;
  } chunk_row_t;

  typedef enum int {
    EndTopNotRiff, EndEof, EndPastEnd, EndTooDeep, EndExceeds
  } ending_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [39:0] cfg_data_i = '0;

  rcw_stream_if #(.payload_t(byte_req_t)) byte_if ();
  rcw_stream_if #(.payload_t(chunk_rec_t)) chunk_if ();

  riff_chunk_walker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (byte_if.sink),
    .out_if     (chunk_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the walker's registers.
  logic [39:0]  file_len = '0;
  bit           stop_on_exceed = 1'b1;
  logic [39:0]  walk_ofs = '0;
  walk_phase_e  walk_ph = WalkId;
  int           field_cnt = 0;
  logic [31:0]  id_acc = '0;
  logic [31:0]  size_acc = '0;
  logic [31:0]  form_acc = '0;
  logic [32:0]  skip_left = '0;
  logic [39:0]  end_stack [MaxNest];
  int           nest_depth = 0;
  bit           walk_halted = 1'b0;
  logic [39:0]  hdr_ofs = '0;
  int           hdr_lvl = 0;
  err_e         hdr_err = ErrNone;

  chunk_rec_t   chunk_q[$];
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  bytes_sent = 0;
  bit           calm = 1'b0;
  int           stall_left = 0;

  function automatic logic [31:0] fourcc(string s);
    return {s[3], s[2], s[1], s[0]};
  endfunction

  function automatic bit is_box(logic [31:0] id);
    return id == TagRiff || id == TagList;
  endfunction

  function automatic chunk_rec_t chunk_rec(logic [31:0] id, logic [31:0] size,
                                           logic [31:0] form, err_e err);
    chunk_rec_t r;
    r.chunk_offset = hdr_ofs;
    r.chunk_id = id;
    r.chunk_size = size;
    r.form_type = form;
    r.nest_level = hdr_lvl[3:0];
    r.is_container = is_box(id);
    r.error_code = err;
    return r;
  endfunction

  // Advances the predicted walker by one file byte; returns 1 when a chunk
  // record is due, which is then placed in r.
  function automatic bit walk_byte(logic [7:0] b, output chunk_rec_t r);
    bit got;
    logic [40:0] padded;
    logic [40:0] data_pos;
    logic [32:0] span;
    got = 1'b0;
    r = '0;
    if (walk_halted) return 1'b0;
    case (walk_ph)
      WalkId: begin
        if (field_cnt == 0) begin
          // Close every container whose end the stream has reached.
          while (nest_depth > 0 && walk_ofs >= end_stack[nest_depth-1]) nest_depth--;
          hdr_ofs = walk_ofs;
          hdr_lvl = nest_depth;
          hdr_err = ErrNone;
          id_acc = '0;
          size_acc = '0;
          form_acc = '0;
          if (walk_ofs >= file_len) begin
            // End of file: silent at top level, an error inside a container.
            walk_halted = 1'b1;
            if (nest_depth == 0) return 1'b0;
            r = chunk_rec('0, '0, '0, ErrPastEnd);
            return 1'b1;
          end
        end
        id_acc[field_cnt*8 +: 8] = b;
        if (field_cnt == 3) begin
          field_cnt = 0;
          walk_ph = WalkSize;
        end else field_cnt++;
      end
      WalkSize: begin
        size_acc[field_cnt*8 +: 8] = b;
        if (field_cnt == 3) begin
          padded = ({9'd0, size_acc} + 41'd1) & ~41'd1;
          data_pos = {1'b0, hdr_ofs} + 41'd8;
          field_cnt = 0;
          walk_ph = WalkId;
          if (hdr_lvl == 0 && id_acc != TagRiff) begin
            r = chunk_rec(id_acc, size_acc, '0, ErrTopNotRiff);
            walk_halted = 1'b1;
            got = 1'b1;
          end else begin
            if (data_pos + padded > {1'b0, file_len}) hdr_err = ErrExceeds;
            if (hdr_err == ErrExceeds && stop_on_exceed) begin
              r = chunk_rec(id_acc, size_acc, '0, ErrExceeds);
              walk_halted = 1'b1;
              got = 1'b1;
            end else if (is_box(id_acc)) begin
              walk_ph = WalkForm;
            end else begin
              r = chunk_rec(id_acc, size_acc, '0, hdr_err);
              got = 1'b1;
              skip_left = padded[32:0];
              if (skip_left != 0) walk_ph = WalkSkip;
            end
          end
        end else field_cnt++;
      end
      WalkForm: begin
        form_acc[field_cnt*8 +: 8] = b;
        if (field_cnt == 3) begin
          field_cnt = 0;
          walk_ph = WalkId;
          if (hdr_lvl >= MaxNest) begin
            r = chunk_rec(id_acc, size_acc, form_acc, ErrTooDeep);
            walk_halted = 1'b1;
          end else begin
            // Nested containers end on an even boundary, top-level ones exactly.
            span = {1'b0, size_acc};
            if (hdr_lvl != 0) span = (span + 33'd1) & ~33'd1;
            end_stack[hdr_lvl] = hdr_ofs + 40'd8 + {7'd0, span};
            nest_depth = hdr_lvl + 1;
            r = chunk_rec(id_acc, size_acc, form_acc, hdr_err);
          end
          got = 1'b1;
        end else field_cnt++;
      end
      default: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) walk_ph = WalkId;
        field_cnt = 0;
      end
    endcase
    walk_ofs = walk_ofs + 40'd1;
    return got;
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch at cycle %0d: %s got %h, expected %h", cycle_cnt, what, got, want);
    fail_cnt++;
  endtask

  // Every accepted byte goes through the predictor.
  always @(posedge clk_i) begin
    chunk_rec_t r;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (walk_byte(byte_if.data.data_byte, r)) chunk_q.push_back(r);
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    chunk_rec_t got;
    chunk_rec_t want;
    if (rst_ni && chunk_if.valid && chunk_if.ready) begin
      got = chunk_if.data;
      if (chunk_q.size() == 0) begin
        $display("unexpected chunk record at cycle %0d: offset %h", cycle_cnt,
                 got.chunk_offset);
        fail_cnt++;
      end else begin
        want = chunk_q.pop_front();
        if (got.chunk_offset !== want.chunk_offset)
          report("chunk_offset", got.chunk_offset, want.chunk_offset);
        if (got.chunk_id !== want.chunk_id) report("chunk_id", got.chunk_id, want.chunk_id);
        if (got.chunk_size !== want.chunk_size)
          report("chunk_size", got.chunk_size, want.chunk_size);
        if (got.form_type !== want.form_type)
          report("form_type", got.form_type, want.form_type);
        if (got.nest_level !== want.nest_level)
          report("nest_level", got.nest_level, want.nest_level);
        if (got.is_container !== want.is_container)
          report("is_container", got.is_container, want.is_container);
        if (got.error_code !== want.error_code)
          report("error_code", got.error_code, want.error_code);
      end
    end
  end

  // Receiver: ready drops in random bursts; no new burst starts once the run has gone calm.
  initial chunk_if.ready = 1'b1;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      chunk_if.ready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 14);
      chunk_if.ready <= 1'b0;
    end else begin
      chunk_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void put_word(ref bytes_t q, input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[i*8 +: 8]);
  endfunction

  // Builds one well-formed chunk at the given depth, with random content.
  // Now and then a nested container claims less than it holds, so the
  // chunks past its claimed end land one level up.
  function automatic bytes_t gen_chunk(int lvl);
    bytes_t q;
    bytes_t body;
    logic [31:0] id;
    logic [31:0] size;
    int n;
    if (lvl == 0 || (lvl < 4 && $urandom_range(0, 3) == 0)) begin
      id = (lvl == 0 || $urandom_range(0, 3) == 0) ? TagRiff : TagList;
      n = $urandom_range(0, lvl == 0 ? 5 : 3);
      repeat (n) body = {body, gen_chunk(lvl + 1)};
      size = 4 + body.size();
      if (lvl > 0 && $urandom_range(0, 7) == 0) size = $urandom_range(0, size);
      put_word(q, id);
      put_word(q, size);
      put_word(q, $urandom);
    end else begin
      id = $urandom;
      size = $urandom_range(0, 12);
      put_word(q, id);
      put_word(q, size);
      repeat (size + size[0]) q.push_back($urandom_range(0, 255));
    end
    return {q, body};
  endfunction

  task automatic send_byte(logic [7:0] b);
    if (!calm && $urandom_range(0, 15) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_file(bytes_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Lets every predicted record arrive and the byte queue run dry, so the
  // walker is idle before a register changes.
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [39:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFileSize) file_len = value;
    else stop_on_exceed = value[0];
  endtask

  initial begin
    chunk_row_t rows[$];
    bytes_t body;
    bytes_t q;
    bytes_t phase_q;
    logic [39:0] len;
    ending_e ending;

    byte_if.valid = 1'b0;
    byte_if.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CfgFileSize, OfsMax);
    write_reg(CfgHaltOnError, 40'd1);

    // Directed file: empty, odd and padded chunks, an empty list, a list too
    // small for its own form type, a list with a child, a nested RIFF, and
    // all-ones / all-zeros ids and form types.
    rows = '{
      '{fourcc("fmt "), 32'd0, 32'd0},
      '{fourcc("data"), 32'd1, 32'd0},
      '{TagList, 32'd4, fourcc("INFO")},
      '{TagList, 32'd0, fourcc("adtl")},
      '{32'hFFFF_FFFF, 32'd2, 32'd0},
      '{32'h0000_0000, 32'd3, 32'd0},
      '{TagList, 32'd16, 32'hFFFF_FFFF},
      '{fourcc("abcd"), 32'd3, 32'd0},
      '{TagRiff, 32'd4, 32'h0000_0000},
      '{fourcc("junk"), 32'd7, 32'd0}
    };
    foreach (rows[i]) begin
      put_word(body, rows[i].id);
      put_word(body, rows[i].size);
      if (is_box(rows[i].id)) put_word(body, rows[i].form);
      else begin
        for (int k = 0; k < rows[i].size + rows[i].size[0]; k++)
          body.push_back(k[0] ? 8'hFF : 8'h00);
      end
    end
    put_word(q, TagRiff);
    put_word(q, 4 + body.size());
    put_word(q, fourcc("WAVE"));
    send_file({q, body});
    settle();

    // Random files, one phase per register setting. The file size is the
    // exact end of the phase, a margin past it, or the largest value.
    while (bytes_sent < ByteGoal) begin
      phase_q.delete();
      while (phase_q.size() < 200) phase_q = {phase_q, gen_chunk(0)};
      len = walk_ofs + phase_q.size();
      case ($urandom_range(0, 2))
        0: write_reg(CfgFileSize, len);
        1: write_reg(CfgFileSize, len + $urandom_range(1, 5000));
        default: write_reg(CfgFileSize, OfsMax);
      endcase
      write_reg(CfgHaltOnError, $urandom_range(0, 1));
      send_file(phase_q);
      settle();
    end

    // The walker halts for good on any of these, so exactly one closes the
    // run, and without idling on either side.
    calm = 1'b1;
    ending = ending_e'($urandom_range(0, 4));
    q.delete();
    case (ending)
      EndTopNotRiff: begin
        put_word(q, fourcc("JUNK"));
        put_word(q, 32'd0);
      end
      EndEof: begin
        write_reg(CfgFileSize, walk_ofs);
        q.push_back($urandom_range(0, 255));
      end
      EndPastEnd: begin
        // The RIFF overruns the file but goes on; its first child starts at
        // the end of the file.
        write_reg(CfgHaltOnError, 40'd0);
        write_reg(CfgFileSize, walk_ofs + 40'd12);
        put_word(q, TagRiff);
        put_word(q, 32'd12);
        put_word(q, $urandom);
        q.push_back($urandom_range(0, 255));
      end
      EndTooDeep: begin
        write_reg(CfgFileSize, OfsMax);
        put_word(q, TagRiff);
        put_word(q, 32'd200);
        put_word(q, $urandom);
        repeat (MaxNest) begin
          put_word(q, TagList);
          put_word(q, 32'd100);
          put_word(q, $urandom);
        end
      end
      default: begin
        write_reg(CfgHaltOnError, 40'd1);
        write_reg(CfgFileSize, walk_ofs + 40'd100);
        put_word(q, TagRiff);
        put_word(q, 32'hFFFF_FFFF);
      end
    endcase
    send_file(q);
    settle();

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rcw_pkg.sv
design/rcw_stream_if.sv
design/rcw_front.sv
design/rcw_back.sv
design/riff_chunk_walker.sv
sim/riff_chunk_walker_tb.sv
